### design/hcbd_pkg.sv
// Shared types, constants and helpers for the chunked body decoder.
`default_nettype none
package hcbd_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam logic [7:0] NEWLINE = 8'h0A;

  typedef enum logic [2:0] {
    PH_SIZE  = 3'd0,
    PH_EXT   = 3'd1,
    PH_DATA  = 3'd2,
    PH_TRAIL = 3'd3,
    PH_DONE  = 3'd4,
    PH_BAD   = 3'd5
  } phase_t;

  // One result of the decoder.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       is_end;
    logic       status;
  } result_t;

  // Bit 4 set when c is a hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - "0")};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - "a" + 8'd10)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - "A" + 8'd10)};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/hcbd_core.sv
// Chunk framing state machine: at most one body byte per accepted request.
`default_nettype none
module hcbd_core #(
  parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    acc,
  input  wire  [7:0]             in_byte,
  input  wire                    in_last,
  output logic                   emit,
  output hcbd_pkg::result_t      res
);
  import hcbd_pkg::*;

  phase_t                  phase, phase_next;
  logic [COUNT_BITS-1:0]   count, count_next;
  logic                    digit_seen, digit_seen_next;
  logic                    has;
  logic [4:0]              hv;

  always_comb begin
    phase_next      = phase;
    count_next      = count;
    digit_seen_next = digit_seen;
    has             = 1'b0;
    hv              = hex_digit(in_byte);
    case (phase)
      PH_SIZE: begin
        if (hv[4]) begin
          // saturate once any of the top nibble is set
          if (count[COUNT_BITS-1 -: 4] != 4'd0) begin
            count_next = '1;
          end else begin
            count_next = {count[COUNT_BITS-5:0], hv[3:0]};
          end
          digit_seen_next = 1'b1;
        end else if (!digit_seen) begin
          phase_next = PH_BAD;
        end else if (in_byte == NEWLINE) begin
          phase_next = (count == '0) ? PH_DONE : PH_DATA;
        end else begin
          phase_next = PH_EXT;
        end
      end
      PH_EXT: begin
        if (in_byte == NEWLINE) begin
          phase_next = (count == '0) ? PH_DONE : PH_DATA;
        end
      end
      PH_DATA: begin
        has        = 1'b1;
        count_next = count - COUNT_BITS'(1);
        if (count == COUNT_BITS'(1)) begin
          phase_next = PH_TRAIL;
        end
      end
      PH_TRAIL: begin
        if (in_byte == NEWLINE) begin
          phase_next      = PH_SIZE;
          count_next      = '0;
          digit_seen_next = 1'b0;
        end
      end
      default: begin
      end
    endcase

    emit         = has | in_last;
    res.has_byte = has;
    res.out_byte = has ? in_byte : 8'd0;
    res.is_end   = in_last;
    res.status   = in_last && (phase_next == PH_BAD);

    // end of body: next byte starts a fresh body
    if (in_last) begin
      phase_next      = PH_SIZE;
      count_next      = '0;
      digit_seen_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_SIZE;
      count      <= '0;
      digit_seen <= 1'b0;
    end else if (acc) begin
      phase      <= phase_next;
      count      <= count_next;
      digit_seen <= digit_seen_next;
    end
  end

`ifndef SYNTHESIS
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    acc && in_last |=> phase == PH_SIZE && count == '0 && !digit_seen)
    else $error("state not cleared after last byte");

  a_data_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> count != '0)
    else $error("data phase with zero remaining count");

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE || phase == PH_BAD) && !(acc && in_last) |=> $stable(phase))
    else $error("terminal phase left before end of body");

  a_bad_no_data: assert property (@(posedge clk) disable iff (rst)
    acc && phase == PH_BAD |-> !has)
    else $error("payload forwarded after malformed header");
`endif

endmodule
`default_nettype wire

### design/http_chunked_body_decoder_top.sv
// Top level of the chunked body decoder: framing core plus two-entry result buffer.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------
//   in      | in_valid / in_ready  | in_byte, in_last
//   out     | out_valid / out_ready| has_byte, out_byte, is_end, status
//
// Each request is decoded in the cycle it is accepted; one request per cycle while in_ready is high.
// A result is registered into the buffer when its request is accepted and reaches out behind any older results.
// Results sit in a two-entry buffer; in_ready drops only when both entries are full.
// Requests that yield no result never occupy the buffer.
// rst is synchronous; it clears the framing state and empties the buffer.
`default_nettype none
module http_chunked_body_decoder_top #(
  parameter int COUNT_BITS = hcbd_pkg::COUNT_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [7:0] in_byte,
  input  wire        in_last,
  output logic       out_valid,
  input  wire        out_ready,
  output logic       has_byte,
  output logic [7:0] out_byte,
  output logic       is_end,
  output logic       status
);
  import hcbd_pkg::*;

  logic      acc;
  logic      emit;
  result_t   res;
  result_t   slots [2];
  logic      wr_ptr, rd_ptr;
  logic [1:0] cnt;
  logic      push, pop;
  result_t   head;

  assign in_ready  = (cnt != 2'd2);
  assign acc       = in_valid && in_ready;
  assign out_valid = (cnt != 2'd0);
  assign push      = acc && emit;
  assign pop       = out_valid && out_ready;

  hcbd_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .in_byte (in_byte),
    .in_last (in_last),
    .emit    (emit),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  assign head     = slots[rd_ptr];
  assign has_byte = head.has_byte;
  assign out_byte = head.out_byte;
  assign is_end   = head.is_end;
  assign status   = head.status;

endmodule
`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for the chunked body decoder top level.
`default_nettype none
module tb_top;
  import hcbd_pkg::*;

  localparam int CNT_W = COUNT_BITS_DEF;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [7:0] CR = 8'h0D;
  localparam int LIMIT = 200000;
  localparam int TARGET_REQS = 550;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
  } body_req_t;

  typedef enum {BODY_GOOD, BODY_CUT, BODY_BAD, BODY_HUGE, BODY_NOISE} body_kind_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       has_byte;
  logic [7:0] out_byte;
  logic       is_end;
  logic       status;

  body_req_t  pend_q[$];
  result_t    payload_q[$];
  logic [7:0] body_q[$];
  body_req_t  drv_req;
  result_t    want;
  int         err_cnt = 0;
  int         sent_cnt = 0;
  int         cyc = 0;
  body_kind_t kind;
  int         pick;
  int         cut;

  // decoder state as tracked by the predictor
  phase_t            ph = PH_SIZE;
  logic [CNT_W-1:0]  remaining = '0;
  logic              got_digit = 1'b0;

  // no idling on either side over this stretch of requests
  wire calm = (sent_cnt >= 200) && (sent_cnt < 320);

  http_chunked_body_decoder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .has_byte  (has_byte),
    .out_byte  (out_byte),
    .is_end    (is_end),
    .status    (status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cyc, msg);
    err_cnt++;
  endtask

  function automatic int unsigned hex_val(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  // advance the decoder by one byte; queue the payload result if one is due
  task automatic decode_byte(input logic [7:0] c, input logic last);
    result_t     r;
    int unsigned v;
    logic        fwd;
    fwd = 1'b0;
    v = hex_val(c);
    case (ph)
      PH_SIZE: begin
        if (v < 16) begin
          if (remaining > ((CNT_MAX - v) >> 4)) remaining = CNT_MAX;
          else remaining = (remaining << 4) + v;
          got_digit = 1'b1;
        end else if (!got_digit) begin
          ph = PH_BAD;
        end else if (c == NEWLINE) begin
          if (remaining == 0) ph = PH_DONE;
          else ph = PH_DATA;
        end else begin
          ph = PH_EXT;
        end
      end
      PH_EXT: begin
        if (c == NEWLINE) begin
          if (remaining == 0) ph = PH_DONE;
          else ph = PH_DATA;
        end
      end
      PH_DATA: begin
        fwd = 1'b1;
        remaining = remaining - 1'b1;
        if (remaining == 0) ph = PH_TRAIL;
      end
      PH_TRAIL: begin
        if (c == NEWLINE) begin
          ph = PH_SIZE;
          remaining = '0;
          got_digit = 1'b0;
        end
      end
      default: ;
    endcase
    if (fwd || last) begin
      r.has_byte = fwd;
      r.out_byte = fwd ? c : 8'h00;
      r.is_end   = last;
      r.status   = last && (ph == PH_BAD);
      payload_q.insert(payload_q.size(), r);
    end
    if (last) begin
      ph = PH_SIZE;
      remaining = '0;
      got_digit = 1'b0;
    end
  endtask

  function automatic logic [7:0] hex_char(input int unsigned d);
    if (d < 10) return 8'("0" + d);
    if ($urandom_range(0, 1) == 1) return 8'("a" + d - 10);
    return 8'("A" + d - 10);
  endfunction

  function automatic logic [7:0] rand_not_nl();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == NEWLINE) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (hex_val(c) != 16) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // append one byte to the body under construction
  task automatic add_byte(input logic [7:0] c);
    body_q.insert(body_q.size(), c);
  endtask

  task automatic put_hex(input longint unsigned n);
    logic [7:0] digs[$];
    do begin
      digs.push_front(hex_char(int'(n % 16)));
      n = n / 16;
    end while (n != 0);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) add_byte("0");
    foreach (digs[i]) add_byte(digs[i]);
  endtask

  // extension, bare CR, or newline right after the digits
  task automatic put_hdr_end();
    int k;
    k = $urandom_range(0, 3);
    if (k == 0) begin
      add_byte(";");
      repeat ($urandom_range(0, 4)) add_byte(rand_not_nl());
    end
    if (k <= 1) add_byte(CR);
    add_byte(NEWLINE);
  endtask

  task automatic put_data(input int n);
    repeat (n) add_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic put_trailer();
    int k;
    k = $urandom_range(0, 3);
    if (k == 0) repeat ($urandom_range(1, 4)) add_byte(rand_not_nl());
    else if (k == 1) add_byte(CR);
    add_byte(NEWLINE);
  endtask

  task automatic put_chunks(input int n);
    int sz;
    repeat (n) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
      put_hex(sz);
      put_hdr_end();
      put_data(sz);
      put_trailer();
    end
  endtask

  task automatic put_good_body();
    put_chunks($urandom_range(1, 4));
    put_hex(0);
    put_hdr_end();
    // bytes past the terminating chunk are ignored
    if ($urandom_range(0, 3) == 0) put_data($urandom_range(1, 5));
  endtask

  task automatic emit_body();
    body_req_t q;
    foreach (body_q[i]) begin
      q.b = body_q[i];
      q.last = (i == body_q.size() - 1);
      pend_q.insert(pend_q.size(), q);
    end
    body_q.delete();
  endtask

  // driver: holds a request until accepted, idles at random otherwise
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      ph = PH_SIZE;
      remaining = '0;
      got_digit = 1'b0;
    end else begin
      if (in_valid && in_ready) decode_byte(in_byte, in_last);
      if (!in_valid || in_ready) begin
        if (pend_q.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
          drv_req = pend_q.pop_front();
          in_valid <= 1'b1;
          in_byte  <= drv_req.b;
          in_last  <= drv_req.last;
          sent_cnt++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (payload_q.size() == 0) begin
          report("result with nothing expected");
        end else begin
          want = payload_q.pop_front();
          if (has_byte !== want.has_byte)
            report($sformatf("has_byte %b, expected %b", has_byte, want.has_byte));
          if (out_byte !== want.out_byte)
            report($sformatf("out_byte %h, expected %h", out_byte, want.out_byte));
          if (is_end !== want.is_end)
            report($sformatf("is_end %b, expected %b", is_end, want.is_end));
          if (status !== want.status)
            report($sformatf("status %b, expected %b", status, want.status));
        end
      end
      out_ready <= calm || ($urandom_range(0, 99) >= 20);
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    // newline right after digits, data extremes, zero-size chunk
    body_q = '{"2", NEWLINE, 8'h00, 8'hFF, NEWLINE, "0", NEWLINE};
    emit_body();
    // non-hex start; later bytes ignored
    body_q = '{"g", "1", NEWLINE};
    emit_body();
    // one-byte body that is malformed on its own last byte
    body_q = '{NEWLINE};
    emit_body();
    // mixed case, extension, early end inside data
    body_q = '{"F", "f", ";", NEWLINE, "a"};
    emit_body();
    // nine digits saturate the size
    body_q = '{"9", "A", "b", "C", "d", "E", "f", "0", "1", NEWLINE, 8'h5A};
    emit_body();

    while (pend_q.size() < TARGET_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) kind = BODY_GOOD;
      else if (pick < 77) kind = BODY_CUT;
      else if (pick < 87) kind = BODY_BAD;
      else if (pick < 95) kind = BODY_HUGE;
      else kind = BODY_NOISE;
      case (kind)
        BODY_GOOD: put_good_body();
        BODY_CUT: begin
          put_good_body();
          cut = $urandom_range(1, body_q.size());
          while (body_q.size() > cut) void'(body_q.pop_back());
        end
        BODY_BAD: begin
          put_chunks($urandom_range(0, 2));
          add_byte(rand_non_hex());
          put_data($urandom_range(0, 4));
        end
        BODY_HUGE: begin
          pick = $urandom_range(0, 3);
          if (pick == 0) put_hex(64'hFFFF_FFFF);
          else if (pick == 1) put_hex(64'h1_0000_0000);
          else put_hex({24'h0, 8'($urandom_range(1, 255)), 32'($urandom)});
          put_hdr_end();
          put_data($urandom_range(1, 6));
        end
        default: put_data($urandom_range(1, 8));
      endcase
      emit_body();
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (pend_q.size() != 0 || in_valid || payload_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
